// ===== hw/rtl/tsalm_pkg.sv =====
`timescale 1ns / 1ps

package tsalm_pkg;

  // Widest lane index over the supported range of lane counts (up to 16 lanes).
  localparam int IdxW = 4;

  // Field widths of the command and result words.
  localparam int LaneFieldW = 3;
  localparam int TimeW      = 32;
  localparam int TagW       = 16;
  localparam int RemapW     = 34;
  localparam int CountW     = 4;
  localparam int StreamW    = 4;

  // Opcodes of an incoming word.
  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_END    = 1'b1;

  // Result status codes.
  localparam logic STATUS_EMIT   = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  // Configuration register indexes.
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_LANE_COUNT = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MAIN_LANE  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_STREAM_MAP = 2'd2;

  // Configuration reset values.
  localparam logic [CountW-1:0]     LANE_COUNT_RST = 4'd8;
  localparam logic [LaneFieldW-1:0] MAIN_LANE_RST  = 3'd0;
  localparam logic [31:0]           STREAM_MAP_RST = 32'h7654_3210;

  // Command passed from the front end to the scan engine.
  typedef struct packed {
    logic                  rej;
    logic [LaneFieldW-1:0] lane;
  } cmd_t;

  // One lane's state as seen by the scan engine.
  typedef struct packed {
    logic             has_first;
    logic             pend_valid;
    logic             ended;
    logic [TimeW-1:0] pend_time;
    logic [TagW-1:0]  pend_tag;
    logic [TimeW-1:0] first_time;
    logic [TimeW-1:0] origin_time;
    logic             origin_ready;
  } lane_rd_t;

  // Completion and pending-clear request from the scan engine.
  typedef struct packed {
    logic            done;
    logic            clr_valid;
    logic [IdxW-1:0] clr_lane;
  } back_fb_t;

endpackage

// ===== hw/rtl/tsalm_front.sv =====
`timescale 1ns / 1ps

module tsalm_front #(
  parameter int LANES = 8,
  localparam int LW = (LANES > 1) ? $clog2(LANES) : 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                opcode_i,
  input  logic [tsalm_pkg::LaneFieldW-1:0]    lane_i,
  input  logic [tsalm_pkg::TimeW-1:0]         timestamp_i,
  input  logic [tsalm_pkg::TagW-1:0]          packet_tag_i,
  input  logic [tsalm_pkg::CountW-1:0]        lane_cnt_i,
  input  logic [LW-1:0]                       main_idx_i,
  output logic                                push_o,
  output tsalm_pkg::cmd_t                     push_cmd_o,
  input  logic [LW-1:0]                       rd_idx_i,
  output tsalm_pkg::lane_rd_t                 rd_o,
  input  tsalm_pkg::back_fb_t                 fb_i
);
  import tsalm_pkg::*;

  logic [LANES-1:0] pend_valid_q, pend_valid_d;
  logic [LANES-1:0] ended_q, ended_d;
  logic [LANES-1:0] has_first_q, has_first_d;
  logic [TimeW-1:0] pend_time_q  [LANES];
  logic [TagW-1:0]  pend_tag_q   [LANES];
  logic [TimeW-1:0] first_time_q [LANES];
  logic [TimeW-1:0] origin_time_q, origin_time_d;
  logic             origin_ready_q, origin_ready_d;
  logic             busy_q, busy_d;

  logic          accept;
  logic          in_range;
  logic [LW-1:0] idx;
  logic          reject;
  logic          take_pkt;
  logic          take_first;
  logic [LW-1:0] clr_idx;

  assign accept   = start_i & ~busy_q;
  assign in_range = ({1'b0, lane_i} < lane_cnt_i);
  assign idx      = LW'(lane_i);
  assign clr_idx  = LW'(fb_i.clr_lane);

  always_comb begin
    if (!in_range) begin
      reject = 1'b1;
    end else if (opcode_i == OP_PACKET) begin
      reject = pend_valid_q[idx] | ended_q[idx];
    end else begin
      reject = 1'b0;
    end
  end

  assign take_pkt   = accept & ~reject & (opcode_i == OP_PACKET);
  assign take_first = take_pkt & ~has_first_q[idx];

  always_comb begin
    pend_valid_d   = pend_valid_q;
    ended_d        = ended_q;
    has_first_d    = has_first_q;
    origin_time_d  = origin_time_q;
    origin_ready_d = origin_ready_q;
    busy_d         = busy_q;
    if (fb_i.clr_valid) begin
      pend_valid_d[clr_idx] = 1'b0;
    end
    if (fb_i.done) begin
      busy_d = 1'b0;
    end
    if (accept) begin
      busy_d = 1'b1;
    end
    if (take_pkt) begin
      pend_valid_d[idx] = 1'b1;
    end
    if (take_first) begin
      has_first_d[idx] = 1'b1;
      if (idx == main_idx_i) begin
        origin_time_d  = timestamp_i;
        origin_ready_d = 1'b1;
      end
    end
    if (accept && !reject && (opcode_i == OP_END)) begin
      ended_d[idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q   <= '0;
      ended_q        <= '0;
      has_first_q    <= '0;
      origin_time_q  <= '0;
      origin_ready_q <= 1'b0;
      busy_q         <= 1'b0;
    end else begin
      pend_valid_q   <= pend_valid_d;
      ended_q        <= ended_d;
      has_first_q    <= has_first_d;
      origin_time_q  <= origin_time_d;
      origin_ready_q <= origin_ready_d;
      busy_q         <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_pkt) begin
      pend_time_q[idx] <= timestamp_i;
      pend_tag_q[idx]  <= packet_tag_i;
    end
    if (take_first) begin
      first_time_q[idx] <= timestamp_i;
    end
  end

  assign busy_o          = busy_q;
  assign push_o          = accept;
  assign push_cmd_o.rej  = reject;
  assign push_cmd_o.lane = lane_i;

  assign rd_o.has_first    = has_first_q[rd_idx_i];
  assign rd_o.pend_valid   = pend_valid_q[rd_idx_i];
  assign rd_o.ended        = ended_q[rd_idx_i];
  assign rd_o.pend_time    = pend_time_q[rd_idx_i];
  assign rd_o.pend_tag     = pend_tag_q[rd_idx_i];
  assign rd_o.first_time   = first_time_q[rd_idx_i];
  assign rd_o.origin_time  = origin_time_q;
  assign rd_o.origin_ready = origin_ready_q;

endmodule

// ===== hw/rtl/tsalm_cmd_fifo.sv =====
`timescale 1ns / 1ps

module tsalm_cmd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tsalm_pkg::cmd_t push_cmd_i,
  input  logic            pop_i,
  output tsalm_pkg::cmd_t pop_cmd_o,
  output logic            empty_o
);
  import tsalm_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push;
  logic       do_pop;

  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i & (cnt_q != 2'd2);
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (do_pop) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  assign pop_cmd_o = mem_q[rd_ptr_q];

endmodule

// ===== hw/rtl/tsalm_back.sv =====
`timescale 1ns / 1ps

module tsalm_back #(
  parameter int LANES = 8,
  localparam int LW = (LANES > 1) ? $clog2(LANES) : 1
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic [tsalm_pkg::CountW-1:0]            lane_cnt_i,
  input  logic [LW-1:0]                           main_idx_i,
  input  logic [31:0]                             stream_map_i,
  input  logic                                    empty_i,
  input  tsalm_pkg::cmd_t                         cmd_i,
  output logic                                    pop_o,
  output logic [LW-1:0]                           rd_idx_o,
  input  tsalm_pkg::lane_rd_t                     rd_i,
  output tsalm_pkg::back_fb_t                     fb_o,
  output logic                                    strobe_o,
  output logic                                    status_o,
  output logic [tsalm_pkg::LaneFieldW-1:0]        out_lane_o,
  output logic [tsalm_pkg::StreamW-1:0]           stream_id_o,
  output logic [tsalm_pkg::TagW-1:0]              out_tag_o,
  output logic signed [tsalm_pkg::RemapW-1:0]     remapped_time_o,
  output logic [tsalm_pkg::TimeW-1:0]             remapped_time_low_o
);
  import tsalm_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [LW-1:0] idx_q, idx_d;
  logic        blk_q, blk_d;

  // Remap stage: one lane's remapped time per cycle.
  logic               cand_q, cand_d;
  logic signed [RemapW-1:0] t_q, t_d;
  logic [LW-1:0]      cidx_q;
  logic [TagW-1:0]    ctag_q;

  // Running minimum.
  logic               found_q, found_d;
  logic signed [RemapW-1:0] best_q, best_d;
  logic [LW-1:0]      sel_q, sel_d;
  logic [TagW-1:0]    btag_q, btag_d;

  // Result word.
  logic               strobe_q, strobe_d;
  logic               status_q, status_d;
  logic [LaneFieldW-1:0] lane_q, lane_d;
  logic [StreamW-1:0] sidx_q, sidx_d;
  logic [TagW-1:0]    tag_q, tag_d;
  logic signed [RemapW-1:0] rt_q, rt_d;

  logic               last;
  logic signed [RemapW-1:0] offset;
  logic [LaneFieldW-1:0] sel3;
  logic               emit;

  assign rd_idx_o = idx_q;
  assign last     = ((5'(idx_q) + 5'd1) == 5'(lane_cnt_i));
  assign pop_o    = (state_q == S_IDLE) & ~empty_i;
  assign sel3     = LaneFieldW'(sel_q);
  assign emit     = (state_q == S_DONE) & found_q & ~blk_q;

  always_comb begin
    if (idx_q != main_idx_i) begin
      offset = $signed({2'b00, rd_i.origin_time}) - $signed({2'b00, rd_i.first_time});
    end else begin
      offset = '0;
    end
    t_d = $signed({2'b00, rd_i.pend_time}) + offset;
  end

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    blk_d    = blk_q;
    cand_d   = 1'b0;
    found_d  = found_q;
    best_d   = best_q;
    sel_d    = sel_q;
    btag_d   = btag_q;
    strobe_d = 1'b0;
    status_d = status_q;
    lane_d   = lane_q;
    sidx_d   = sidx_q;
    tag_d    = tag_q;
    rt_d     = rt_q;

    fb_o.done      = 1'b0;
    fb_o.clr_valid = 1'b0;
    fb_o.clr_lane  = IdxW'(sel_q);

    // Compare stage runs behind the remap stage.
    if (cand_q && (!found_q || (t_q < best_q))) begin
      found_d = 1'b1;
      best_d  = t_q;
      sel_d   = cidx_q;
      btag_d  = ctag_q;
    end

    case (state_q)
      S_IDLE: begin
        if (pop_o) begin
          if (cmd_i.rej) begin
            strobe_d  = 1'b1;
            status_d  = STATUS_REJECT;
            lane_d    = cmd_i.lane;
            sidx_d    = '0;
            tag_d     = '0;
            rt_d      = '0;
            fb_o.done = 1'b1;
          end else begin
            state_d = S_SCAN;
            idx_d   = '0;
            blk_d   = ~rd_i.origin_ready;
            found_d = 1'b0;
          end
        end
      end
      S_SCAN: begin
        blk_d  = blk_q | ~rd_i.has_first | (~rd_i.pend_valid & ~rd_i.ended);
        cand_d = rd_i.pend_valid;
        if (last) begin
          state_d = S_DRAIN;
        end else begin
          idx_d = idx_q + LW'(1);
        end
      end
      S_DRAIN: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        fb_o.done      = 1'b1;
        fb_o.clr_valid = emit;
        if (emit) begin
          strobe_d = 1'b1;
          status_d = STATUS_EMIT;
          lane_d   = sel3;
          sidx_d   = stream_map_i[{sel3, 2'b00} +: StreamW];
          tag_d    = btag_q;
          rt_d     = best_q;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      blk_q    <= 1'b0;
      cand_q   <= 1'b0;
      found_q  <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      blk_q    <= blk_d;
      cand_q   <= cand_d;
      found_q  <= found_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q      <= t_d;
    cidx_q   <= idx_q;
    ctag_q   <= rd_i.pend_tag;
    best_q   <= best_d;
    sel_q    <= sel_d;
    btag_q   <= btag_d;
    status_q <= status_d;
    lane_q   <= lane_d;
    sidx_q   <= sidx_d;
    tag_q    <= tag_d;
    rt_q     <= rt_d;
  end

  assign strobe_o            = strobe_q;
  assign status_o            = status_q;
  assign out_lane_o          = lane_q;
  assign stream_id_o         = sidx_q;
  assign out_tag_o           = tag_q;
  assign remapped_time_o     = rt_q;
  assign remapped_time_low_o = rt_q[TimeW-1:0];

endmodule

// ===== hw/rtl/timestamp_aligned_lane_merge.sv =====
`timescale 1ns / 1ps

// Timestamp-aligned lane merge.
// A command word is taken at a rising edge where start_i is high and busy_o is
// low. It either delivers a packet (timestamp and tag) to a lane or marks a
// lane as ended. Each accepted word produces at most one result word, shown on
// the result ports for exactly one cycle with strobe_o high: either a reject
// (status 1) or the lane head with the smallest remapped timestamp (status 0).
// The receiver cannot stall; every strobed result must be taken as it passes.
// A word passes through the command queue to the scan engine, which walks the
// lane heads in use one per cycle and adds one remap stage and one compare
// stage; a reject is answered as it leaves the queue, without a scan.
// busy_o stays high until the word is finished, so a new word is taken only
// once the last one is done, whether it was a packet, an end or a reject.
// Configuration registers are written through cfg_we_i, cfg_idx_i and
// cfg_wdata_i, and should only be written while busy_o is low.
// Reset clears every lane flag and the time origin, returns the configuration
// to its reset values, and the block is ready to accept a word in the first
// cycle after reset.
module timestamp_aligned_lane_merge #(
  parameter int LANES = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                opcode_i,
  input  logic [tsalm_pkg::LaneFieldW-1:0]    lane_i,
  input  logic [tsalm_pkg::TimeW-1:0]         timestamp_i,
  input  logic [tsalm_pkg::TagW-1:0]          packet_tag_i,
  input  logic                                cfg_we_i,
  input  logic [tsalm_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [31:0]                         cfg_wdata_i,
  output logic                                strobe_o,
  output logic                                status_o,
  output logic [tsalm_pkg::LaneFieldW-1:0]    out_lane_o,
  output logic [tsalm_pkg::StreamW-1:0]       stream_id_o,
  output logic [tsalm_pkg::TagW-1:0]          out_tag_o,
  output logic signed [tsalm_pkg::RemapW-1:0] remapped_time_o,
  output logic [tsalm_pkg::TimeW-1:0]         remapped_time_low_o
);
  import tsalm_pkg::*;

  localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;

  // Configuration registers.
  logic [CountW-1:0]     lane_count_q;
  logic [LaneFieldW-1:0] main_lane_q;
  logic [31:0]           stream_map_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_count_q <= LANE_COUNT_RST;
      main_lane_q  <= MAIN_LANE_RST;
      stream_map_q <= STREAM_MAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LANE_COUNT: lane_count_q <= cfg_wdata_i[CountW-1:0];
        REG_MAIN_LANE:  main_lane_q  <= cfg_wdata_i[LaneFieldW-1:0];
        REG_STREAM_MAP: stream_map_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Effective lane count: zero acts as one, and the count is capped at the
  // number of lanes built. The main lane falls back to lane 0 when it is not
  // in use.
  logic [CountW-1:0] lc_nz;
  logic [CountW-1:0] lane_cnt;
  logic [LW-1:0]     main_idx;

  assign lc_nz    = (lane_count_q == '0) ? CountW'(1) : lane_count_q;
  assign lane_cnt = ({1'b0, lc_nz} > 5'(LANES)) ? CountW'(LANES) : lc_nz;
  assign main_idx = ({1'b0, main_lane_q} < lane_cnt) ? LW'(main_lane_q) : '0;

  // Front end to queue, queue to scan engine, scan engine back to lane state.
  logic     push;
  cmd_t     push_cmd;
  logic     pop;
  cmd_t     pop_cmd;
  logic     empty;
  logic [LW-1:0] rd_idx;
  lane_rd_t rd;
  back_fb_t fb;

  tsalm_front #(
    .LANES(LANES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .opcode_i     (opcode_i),
    .lane_i       (lane_i),
    .timestamp_i  (timestamp_i),
    .packet_tag_i (packet_tag_i),
    .lane_cnt_i   (lane_cnt),
    .main_idx_i   (main_idx),
    .push_o       (push),
    .push_cmd_o   (push_cmd),
    .rd_idx_i     (rd_idx),
    .rd_o         (rd),
    .fb_i         (fb)
  );

  tsalm_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd),
    .empty_o    (empty)
  );

  tsalm_back #(
    .LANES(LANES)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .lane_cnt_i          (lane_cnt),
    .main_idx_i          (main_idx),
    .stream_map_i        (stream_map_q),
    .empty_i             (empty),
    .cmd_i               (pop_cmd),
    .pop_o               (pop),
    .rd_idx_o            (rd_idx),
    .rd_i                (rd),
    .fb_o                (fb),
    .strobe_o            (strobe_o),
    .status_o            (status_o),
    .out_lane_o          (out_lane_o),
    .stream_id_o         (stream_id_o),
    .out_tag_o           (out_tag_o),
    .remapped_time_o     (remapped_time_o),
    .remapped_time_low_o (remapped_time_low_o)
  );

endmodule

// ===== sim/timestamp_aligned_lane_merge_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the timestamp-aligned lane merge.
//
// Command words go in through the start/busy handshake. Each result word is
// shown for exactly one cycle under strobe_o. The receiving side cannot push
// back, so the bench takes every strobed word as it passes. Every accepted
// command is run through a behavioural copy of the merge kept in this module.
// That copy holds the lane heads, the first timestamps, the time origin and
// the configuration. Whatever result word it produces is queued and compared
// field by field with the next strobed word.
//
// The run opens with a short scripted sequence. It covers the range limits of
// the fields, both opcodes and the corner cases of the merge: lane count zero
// and above the lane total, a main lane outside the lanes in use, rejects for
// busy and unused lanes, recapture of the time origin, an ended lane that
// never started, and a repeated end. After that come randomised phases. Each
// phase waits for the block to go quiet, rewrites some registers and then
// sends bursts of words. Most of them are packets aimed at free lanes, which
// keeps the merge emitting. The rest is noise, lane ends late in the run, and
// repeated ends once no lane is free, which drain what is still held.
module timestamp_aligned_lane_merge_tb;
  import tsalm_pkg::*;

  localparam int LANES        = 8;
  localparam int RANDOM_ITEMS = 530;
  // Longer than the block needs to finish any word, so a safe quiet period.
  localparam int SETTLE       = LANES + 8;
  localparam int CYCLE_LIMIT  = 400000;

  // One result word as it appears on the output ports.
  typedef struct packed {
    logic                     status;
    logic [LaneFieldW-1:0]    lane;
    logic [StreamW-1:0]       stream;
    logic [TagW-1:0]          tag;
    logic signed [RemapW-1:0] rtime;
    logic [TimeW-1:0]         rtime_low;
  } merge_word_t;

  // How a scripted row is checked. A row with a typed result uses that result
  // in place of the behavioural one, and a quiet row expects no word at all.
  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_PREDICT,
    ROW_QUIET,
    ROW_FIXED
  } row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CfgIdxW-1:0]    reg_idx;
    logic [31:0]           reg_val;
    logic                  op;
    logic [LaneFieldW-1:0] lane;
    logic [TimeW-1:0]      ts;
    logic [TagW-1:0]       tag;
    merge_word_t           fixed;
  } script_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  logic opcode_i;
  logic [LaneFieldW-1:0] lane_i;
  logic [TimeW-1:0] timestamp_i;
  logic [TagW-1:0] packet_tag_i;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [31:0] cfg_wdata_i;
  logic strobe_o;
  logic status_o;
  logic [LaneFieldW-1:0] out_lane_o;
  logic [StreamW-1:0] stream_id_o;
  logic [TagW-1:0] out_tag_o;
  logic signed [RemapW-1:0] remapped_time_o;
  logic [TimeW-1:0] remapped_time_low_o;

  // Configuration as the block should currently see it.
  logic [CountW-1:0] cfg_lane_count = LANE_COUNT_RST;
  logic [LaneFieldW-1:0] cfg_main_lane = MAIN_LANE_RST;
  logic [31:0] cfg_stream_map = STREAM_MAP_RST;

  // Lane state of the behavioural merge.
  bit lane_held [LANES];
  bit lane_done [LANES];
  bit lane_started [LANES];
  logic [TimeW-1:0] held_time [LANES];
  logic [TagW-1:0] held_tag [LANES];
  logic [TimeW-1:0] start_time [LANES];
  logic [TimeW-1:0] origin_ts = '0;
  bit origin_set = 1'b0;

  merge_word_t merged_words_q[$];
  script_row_t plan_q[$];
  int fail_count = 0;
  int cycle_count = 0;
  // Slowly advancing media clock, so that many packets sit close together.
  logic [TimeW-1:0] media_clock = 32'h0001_0000;

  timestamp_aligned_lane_merge #(
    .LANES(LANES)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .opcode_i           (opcode_i),
    .lane_i             (lane_i),
    .timestamp_i        (timestamp_i),
    .packet_tag_i       (packet_tag_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .strobe_o           (strobe_o),
    .status_o           (status_o),
    .out_lane_o         (out_lane_o),
    .stream_id_o        (stream_id_o),
    .out_tag_o          (out_tag_o),
    .remapped_time_o    (remapped_time_o),
    .remapped_time_low_o(remapped_time_low_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // A lane count of zero behaves as one, and anything above the lane total
  // is clipped to it.
  function automatic int unsigned active_lanes();
    int unsigned n;
    n = cfg_lane_count;
    if (n == 0) n = 1;
    if (n > LANES) n = LANES;
    return n;
  endfunction

  // The main lane falls back to lane 0 when it lies outside the lanes in use.
  function automatic int unsigned origin_lane();
    return (cfg_main_lane < active_lanes()) ? cfg_main_lane : 0;
  endfunction

  // Applies one accepted word to the behavioural merge. Returns 1 when the
  // word causes a result word, which is then left in w.
  function automatic bit merge_apply(input logic op, input logic [LaneFieldW-1:0] ln,
                                     input logic [TimeW-1:0] ts, input logic [TagW-1:0] tag,
                                     output merge_word_t w);
    int unsigned n;
    int unsigned m;
    int sel;
    longint best;
    longint t;
    longint org;
    longint fst;
    bit refuse;
    n = active_lanes();
    w = '0;
    if (op == OP_PACKET) refuse = (ln >= n) || lane_held[ln] || lane_done[ln];
    else refuse = (ln >= n);
    if (refuse) begin
      // A reject leaves the lane state untouched and echoes the lane.
      w.status = STATUS_REJECT;
      w.lane = ln;
      return 1'b1;
    end
    if (op == OP_PACKET) begin
      if (!lane_started[ln]) begin
        lane_started[ln] = 1'b1;
        start_time[ln] = ts;
        // The origin is taken from whichever lane is main at this moment.
        if (ln == origin_lane()) begin
          origin_ts = ts;
          origin_set = 1'b1;
        end
      end
      held_time[ln] = ts;
      held_tag[ln] = tag;
      lane_held[ln] = 1'b1;
    end else begin
      lane_done[ln] = 1'b1;
    end
    // Emission waits for the origin, a first timestamp on every lane in use,
    // and a packet or an end on each of them.
    if (!origin_set) return 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!lane_started[i] || (!lane_held[i] && !lane_done[i])) return 1'b0;
    end
    m = origin_lane();
    sel = -1;
    best = 0;
    for (int i = 0; i < n; i++) begin
      if (lane_held[i]) begin
        t = held_time[i];
        if (i != m) begin
          org = origin_ts;
          fst = start_time[i];
          t = t + org - fst;
        end
        // Strictly smaller only, so the lowest lane keeps a tie.
        if (sel < 0 || t < best) begin
          best = t;
          sel = i;
        end
      end
    end
    if (sel < 0) return 1'b0;
    lane_held[sel] = 1'b0;
    w.status = STATUS_EMIT;
    w.lane = sel[LaneFieldW-1:0];
    w.stream = cfg_stream_map[4*sel +: 4];
    w.tag = held_tag[sel];
    w.rtime = best[RemapW-1:0];
    w.rtime_low = best[TimeW-1:0];
    return 1'b1;
  endfunction

  function automatic merge_word_t reject_of(input logic [LaneFieldW-1:0] ln);
    merge_word_t w;
    w = '0;
    w.status = STATUS_REJECT;
    w.lane = ln;
    return w;
  endfunction

  // Timestamps: the extremes, values just after the media clock, or anything.
  function automatic logic [TimeW-1:0] pick_time();
    int unsigned roll;
    roll = $urandom_range(0, 7);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    if (roll < 5) begin
      media_clock = media_clock + $urandom_range(0, 40);
      return media_clock + $urandom_range(0, 1000);
    end
    return $urandom;
  endfunction

  task automatic add_cfg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    script_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    plan_q = {plan_q, r};
  endtask

  task automatic add_word(input row_kind_e kind, input logic op,
                          input logic [LaneFieldW-1:0] ln, input logic [TimeW-1:0] ts,
                          input logic [TagW-1:0] tag, input merge_word_t fixed);
    script_row_t r;
    r = '0;
    r.kind = kind;
    r.op = op;
    r.lane = ln;
    r.ts = ts;
    r.tag = tag;
    r.fixed = fixed;
    plan_q = {plan_q, r};
  endtask

  // Holds start low until every expected word has arrived and the block has
  // had time to finish any word that produces nothing.
  task automatic settle_idle();
    start_i <= 1'b0;
    while (merged_words_q.size() != 0 || busy_o) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    settle_idle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_LANE_COUNT: cfg_lane_count = val[CountW-1:0];
      REG_MAIN_LANE:  cfg_main_lane = val[LaneFieldW-1:0];
      REG_STREAM_MAP: cfg_stream_map = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic idle_gap(input int unsigned cycles);
    start_i <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // Presents one command word from a falling edge and holds it until the
  // block takes it. The expectation is queued at the accepting edge, well
  // ahead of the earliest possible result.
  task automatic send_word(input logic op, input logic [LaneFieldW-1:0] ln,
                           input logic [TimeW-1:0] ts, input logic [TagW-1:0] tag,
                           input row_kind_e kind, input merge_word_t fixed);
    merge_word_t w;
    bit produced;
    start_i <= 1'b1;
    opcode_i <= op;
    lane_i <= ln;
    timestamp_i <= ts;
    packet_tag_i <= tag;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    produced = merge_apply(op, ln, ts, tag, w);
    case (kind)
      ROW_FIXED: merged_words_q = {merged_words_q, fixed};
      ROW_QUIET: ;
      default: if (produced) merged_words_q = {merged_words_q, w};
    endcase
    @(negedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Result words are taken at the rising edge that ends their strobe cycle.
  always @(posedge clk_i) begin
    merge_word_t want;
    if (rst_ni && strobe_o) begin
      if (merged_words_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual status %0b lane %0d",
                 $time, status_o, out_lane_o);
        fail_count++;
      end else begin
        want = merged_words_q.pop_front();
        check_field("status", want.status, status_o);
        check_field("out_lane", want.lane, out_lane_o);
        check_field("stream_id", want.stream, stream_id_o);
        check_field("out_tag", want.tag, out_tag_o);
        check_field("remapped_time", want.rtime, remapped_time_o);
        check_field("remapped_time_low", want.rtime_low, remapped_time_low_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run timed out with %0d words outstanding", $time,
               merged_words_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned open_q[$];
    int unsigned ended_q[$];
    int unsigned n;
    int unsigned roll;
    int unsigned phase_len;
    int unsigned burst_left;
    int unsigned items_done;
    logic [3:0] lc;
    logic [31:0] map_val;
    logic op;
    logic [LaneFieldW-1:0] ln;
    logic [TimeW-1:0] ts;
    logic [TagW-1:0] tag;

    rst_ni = 1'b0;
    start_i = 1'b0;
    opcode_i = OP_PACKET;
    lane_i = '0;
    timestamp_i = '0;
    packet_tag_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_LANE_COUNT;
    cfg_wdata_i = '0;

    // Two lanes: lane 0 sets the origin at 0, and lane 1 starts at the top of
    // the range, which gives it the most negative offset possible.
    add_cfg(REG_LANE_COUNT, 32'd2);
    add_word(ROW_QUIET, OP_PACKET, 3'd0, 32'h0000_0000, 16'h0000, '0);
    // Packet on a lane that already holds one.
    add_word(ROW_FIXED, OP_PACKET, 3'd0, 32'h0000_0005, 16'h5555, reject_of(3'd0));
    // Both heads remap to 0, so lane 0 wins the tie.
    add_word(ROW_FIXED, OP_PACKET, 3'd1, 32'hFFFF_FFFF, 16'hFFFF,
             '{status: STATUS_EMIT, lane: 3'd0, stream: 4'd0, tag: 16'h0000,
               rtime: 34'sd0, rtime_low: 32'd0});
    add_word(ROW_PREDICT, OP_PACKET, 3'd0, 32'h0000_0000, 16'h1234, '0);
    add_word(ROW_PREDICT, OP_PACKET, 3'd0, 32'hFFFF_FFFF, 16'hABCD, '0);
    // Lane 1 at time 0 lands at the bottom of the remapped range.
    add_word(ROW_PREDICT, OP_PACKET, 3'd1, 32'h0000_0000, 16'h00FF, '0);
    // Packet and end on lanes outside the two in use.
    add_word(ROW_FIXED, OP_PACKET, 3'd2, 32'h0000_0007, 16'h0007, reject_of(3'd2));
    add_word(ROW_FIXED, OP_END, 3'd3, 32'h0000_0000, 16'h0000, reject_of(3'd3));
    // A lane count of zero leaves only lane 0 in use.
    add_cfg(REG_LANE_COUNT, 32'd0);
    add_word(ROW_FIXED, OP_END, 3'd1, 32'h0000_0000, 16'h0000, reject_of(3'd1));
    // Main lane 6 is not in use with four lanes, so lane 0 stays the origin.
    add_cfg(REG_MAIN_LANE, 32'd6);
    add_cfg(REG_LANE_COUNT, 32'd4);
    add_word(ROW_QUIET, OP_PACKET, 3'd2, 32'h8000_0000, 16'h0002, '0);
    // Lane 3 becomes main before it starts, so its first packet moves the
    // origin to the top of the range.
    add_cfg(REG_MAIN_LANE, 32'd3);
    add_word(ROW_PREDICT, OP_PACKET, 3'd3, 32'hFFFF_FFFF, 16'h0003, '0);
    add_word(ROW_PREDICT, OP_PACKET, 3'd1, 32'h0000_0010, 16'h0011, '0);
    add_cfg(REG_STREAM_MAP, 32'hFFFF_FFFF);
    add_word(ROW_PREDICT, OP_PACKET, 3'd1, 32'hFFFF_FFFF, 16'h0022, '0);
    // Fifteen lanes act as eight. Lane 7 ends before it ever starts, which
    // stalls emission for as long as eight lanes are in use.
    add_cfg(REG_LANE_COUNT, 32'd15);
    add_word(ROW_QUIET, OP_END, 3'd7, 32'h0000_0000, 16'h0000, '0);
    // A second end on the same lane is taken but changes nothing.
    add_word(ROW_QUIET, OP_END, 3'd7, 32'h0000_0000, 16'h0000, '0);
    add_word(ROW_PREDICT, OP_PACKET, 3'd0, 32'h0000_0000, 16'hFFFF, '0);
    // Back to three lanes, which takes lane 7 out of the way again.
    add_cfg(REG_STREAM_MAP, 32'h0000_0000);
    add_cfg(REG_LANE_COUNT, 32'd3);
    add_word(ROW_PREDICT, OP_PACKET, 3'd2, 32'h0000_0001, 16'h8000, '0);

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan_q[k]) begin
      if (plan_q[k].kind == ROW_CFG) begin
        set_reg(plan_q[k].reg_idx, plan_q[k].reg_val);
      end else begin
        send_word(plan_q[k].op, plan_q[k].lane, plan_q[k].ts, plan_q[k].tag,
                  plan_q[k].kind, plan_q[k].fixed);
        if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 6));
      end
    end

    items_done = 0;
    while (items_done < RANDOM_ITEMS) begin
      // Every phase starts from a quiet block. The lane count leans towards
      // the counts that still emit, but the extremes come up regularly.
      roll = $urandom_range(0, 19);
      case (roll)
        0: lc = 4'd0;
        1: lc = 4'd15;
        2: lc = 4'd8;
        3: lc = 4'd9;
        default: lc = 4'($urandom_range(1, LANES - 1));
      endcase
      set_reg(REG_LANE_COUNT, {28'd0, lc});
      if ($urandom_range(0, 1) == 1) set_reg(REG_MAIN_LANE, $urandom_range(0, 7));
      if ($urandom_range(0, 2) == 0) begin
        roll = $urandom_range(0, 3);
        map_val = (roll == 0) ? 32'h0000_0000 : (roll == 1) ? 32'hFFFF_FFFF : $urandom;
        set_reg(REG_STREAM_MAP, map_val);
      end
      // With all eight lanes in use the merge stays stalled, so keep it short.
      phase_len = (active_lanes() == LANES) ? $urandom_range(6, 12) : $urandom_range(10, 50);
      burst_left = $urandom_range(1, 16);
      for (int unsigned k = 0; k < phase_len && items_done < RANDOM_ITEMS; k++) begin
        n = active_lanes();
        open_q.delete();
        ended_q.delete();
        for (int unsigned i = 0; i < n; i++) begin
          if (lane_done[i]) ended_q = {ended_q, i};
          else if (!lane_held[i]) open_q = {open_q, i};
        end
        roll = $urandom_range(0, 99);
        ts = pick_time();
        tag = TagW'($urandom_range(0, 16'hFFFF));
        if (roll < 10 || (open_q.size() == 0 && ended_q.size() == 0)) begin
          // Noise: anything at all, mostly rejects.
          op = 1'($urandom_range(0, 1));
          ln = LaneFieldW'($urandom_range(0, 7));
          ts = $urandom;
        end else if (open_q.size() == 0) begin
          // Every lane is full or ended: a repeated end drains a held packet.
          op = OP_END;
          ln = LaneFieldW'(ended_q[$urandom_range(0, ended_q.size() - 1)]);
        end else if (roll < 14 && items_done > (3 * RANDOM_ITEMS) / 4) begin
          op = OP_END;
          ln = LaneFieldW'($urandom_range(0, n - 1));
        end else begin
          op = OP_PACKET;
          ln = LaneFieldW'(open_q[$urandom_range(0, open_q.size() - 1)]);
        end
        send_word(op, ln, ts, tag, ROW_PREDICT, '0);
        items_done++;
        burst_left--;
        if (burst_left == 0) begin
          if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 14));
          burst_left = $urandom_range(1, 16);
        end
      end
    end

    settle_idle();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/tsalm_pkg.sv
hw/rtl/tsalm_front.sv
hw/rtl/tsalm_cmd_fifo.sv
hw/rtl/tsalm_back.sv
hw/rtl/timestamp_aligned_lane_merge.sv
sim/timestamp_aligned_lane_merge_tb.sv
